FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL files; sha256_message_hasher includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication or plain property, checked on every clock outside reset.
`define SHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define SHM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/shm_pkg.sv
package shm_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  typedef struct packed {
    logic             re;
    logic [2:0]       raddr;
    logic             we;
    logic [2:0]       waddr;
    logic [WordW-1:0] wdata;
    logic             clear;
  } chain_req_t;

  function automatic logic [31:0] shm_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] shm_k(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] shm_bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] shm_bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] shm_ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] shm_ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: rtl/shm_chain_store.sv
module shm_chain_store
  import shm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  chain_req_t       req,
  output logic [WordW-1:0] rd_data
);

  logic [WordW-1:0] mem [0:7];
  logic [WordW-1:0] rd_r;
  logic [2:0]       rd_idx_r;
  logic             rd_vld_r;
  logic [7:0]       vld_r;
  logic [7:0]       vld_nxt;

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_r     <= mem[req.raddr];
      rd_idx_r <= req.raddr;
      rd_vld_r <= vld_r[req.raddr];
    end
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (req.we) begin
      vld_nxt[req.waddr] = 1'b1;
    end
    if (req.clear) begin
      vld_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // unwritten entries read as the initial hash
  assign rd_data = rd_vld_r ? rd_r : shm_iv(rd_idx_r);

endmodule

FILE: rtl/sha256_message_hasher.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | data_word, valid_bytes, end_of_message
// out     | output    | out_valid/out_stall| digest_word, word_index, digest_done
//
// A word is accepted in ST_IDLE; ST_PACK then packs its valid bytes into the block buffer.
// Each full 64-byte block is compressed: chain loads, 64 rounds, chain updates.
// The last word adds padding (marker, zero bytes, 64-bit length), compressing one or two
// more blocks, then sends each digest word; ST_OUT_WR waits while out_stall holds.
// Reset is synchronous and active low; no clearing pass is needed.
// in_stall is high whenever a word is in work; the output register frees the input side.
module sha256_message_hasher
  import shm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_done
);

`include "assert_macros.svh"

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PACK     = 4'd1;
  localparam logic [3:0] ST_PAD_MARK = 4'd2;
  localparam logic [3:0] ST_PAD_ZERO = 4'd3;
  localparam logic [3:0] ST_PAD_LEN  = 4'd4;
  localparam logic [3:0] ST_LOAD     = 4'd5;
  localparam logic [3:0] ST_ROUND    = 4'd6;
  localparam logic [3:0] ST_FINAL    = 4'd7;
  localparam logic [3:0] ST_OUT_RD   = 4'd8;
  localparam logic [3:0] ST_OUT_WR   = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  ret_r, ret_nxt;
  logic [6:0]  step_r, step_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  len_cnt_r, len_cnt_nxt;
  logic        last_r, last_nxt;
  logic [60:0] byte_cnt_r, byte_cnt_nxt;
  logic [31:0] byte_sr_r, byte_sr_nxt;
  logic [31:0] cur_word_r, cur_word_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_done_r, out_done_nxt;

  logic [31:0] work_r  [0:7];
  logic [31:0] work_nxt [0:7];
  logic [31:0] sched_r [0:15];
  logic [31:0] sched_nxt [0:15];

  logic [31:0] buf_mem [0:15];
  logic [31:0] buf_rd_r;
  logic        buf_re;
  logic [3:0]  buf_raddr;
  logic        buf_we;
  logic [3:0]  buf_waddr;

  chain_req_t  chain_req;
  logic [31:0] chain_rd;

  logic        in_xfer;
  logic [2:0]  in_cnt;
  logic        put_en;
  logic [7:0]  put_val;
  logic [3:0]  after_st;
  logic [63:0] len_bits;
  logic [2:0]  len_sel;
  logic [31:0] w_t;
  logic [31:0] t1;
  logic [31:0] t2;
  logic        out_free;

  shm_chain_store u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (chain_req),
    .rd_data (chain_rd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign in_cnt    = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign len_bits  = {byte_cnt_r, 3'b000};
  assign len_sel   = 3'd7 - len_cnt_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign w_t = (step_r < 7'd16) ? buf_rd_r :
               sched_r[0] + shm_ssig0(sched_r[1]) + sched_r[9] + shm_ssig1(sched_r[14]);
  assign t1  = work_r[7] + shm_bsig1(work_r[4])
             + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
             + shm_k(step_r[5:0]) + w_t;
  assign t2  = shm_bsig0(work_r[0])
             + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    len_cnt_nxt   = len_cnt_r;
    last_nxt      = last_r;
    byte_cnt_nxt  = byte_cnt_r;
    byte_sr_nxt   = byte_sr_r;
    cur_word_nxt  = cur_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_done_nxt  = out_done_r;
    for (int i = 0; i < 8; i++) begin
      work_nxt[i] = work_r[i];
    end
    for (int i = 0; i < 16; i++) begin
      sched_nxt[i] = sched_r[i];
    end
    buf_re          = 1'b0;
    buf_raddr       = 4'd0;
    chain_req       = '0;
    put_en          = 1'b0;
    put_val         = 8'd0;
    after_st        = state_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          byte_sr_nxt = in_data_word;
          cnt_nxt     = in_cnt;
          last_nxt    = in_end_of_message;
          if (in_cnt != 3'd0) begin
            state_nxt = ST_PACK;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD_MARK;
          end
        end
      end
      ST_PACK: begin
        put_en       = 1'b1;
        put_val      = byte_sr_r[31:24];
        byte_sr_nxt  = {byte_sr_r[23:0], 8'd0};
        cnt_nxt      = cnt_r - 3'd1;
        byte_cnt_nxt = byte_cnt_r + 61'd1;
        if (cnt_r == 3'd1) begin
          after_st = last_r ? ST_PAD_MARK : ST_IDLE;
        end else begin
          after_st = ST_PACK;
        end
      end
      ST_PAD_MARK: begin
        put_en   = 1'b1;
        put_val  = PadMark;
        after_st = ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (pos_r == LenPos) begin
          len_cnt_nxt = 3'd0;
          state_nxt   = ST_PAD_LEN;
        end else begin
          put_en   = 1'b1;
          after_st = ST_PAD_ZERO;
        end
      end
      ST_PAD_LEN: begin
        put_en      = 1'b1;
        put_val     = len_bits[{len_sel, 3'b000} +: 8];
        len_cnt_nxt = len_cnt_r + 3'd1;
        after_st    = (len_cnt_r == 3'd7) ? ST_OUT_RD : ST_PAD_LEN;
      end
      ST_LOAD: begin
        if (step_r < 7'd8) begin
          chain_req.re    = 1'b1;
          chain_req.raddr = step_r[2:0];
        end
        if (step_r != 7'd0) begin
          for (int i = 0; i < 7; i++) begin
            work_nxt[i] = work_r[i+1];
          end
          work_nxt[7] = chain_rd;
        end
        if (step_r == 7'd8) begin
          buf_re    = 1'b1;
          buf_raddr = 4'd0;
          step_nxt  = 7'd0;
          state_nxt = ST_ROUND;
        end else begin
          step_nxt = step_r + 7'd1;
        end
      end
      ST_ROUND: begin
        buf_re    = 1'b1;
        buf_raddr = step_r[3:0] + 4'd1;
        for (int i = 0; i < 15; i++) begin
          sched_nxt[i] = sched_r[i+1];
        end
        sched_nxt[15] = w_t;
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
        if (step_r == 7'(Rounds - 1)) begin
          step_nxt  = 7'd0;
          state_nxt = ST_FINAL;
        end else begin
          step_nxt = step_r + 7'd1;
        end
      end
      ST_FINAL: begin
        if (step_r < 7'd8) begin
          chain_req.re    = 1'b1;
          chain_req.raddr = step_r[2:0];
        end
        if (step_r != 7'd0) begin
          chain_req.we    = 1'b1;
          chain_req.waddr = step_r[2:0] - 3'd1;
          chain_req.wdata = chain_rd + work_r[0];
          for (int i = 0; i < 7; i++) begin
            work_nxt[i] = work_r[i+1];
          end
          work_nxt[7] = work_r[0];
        end
        if (step_r == 7'd8) begin
          step_nxt  = 7'd0;
          state_nxt = ret_r;
        end else begin
          step_nxt = step_r + 7'd1;
        end
      end
      ST_OUT_RD: begin
        chain_req.re    = 1'b1;
        chain_req.raddr = step_r[2:0];
        state_nxt       = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain_rd;
          out_idx_nxt   = step_r[2:0];
          out_done_nxt  = (step_r[2:0] == 3'd7);
          if (step_r[2:0] == 3'd7) begin
            chain_req.clear = 1'b1;
            step_nxt        = 7'd0;
            byte_cnt_nxt    = '0;
            state_nxt       = ST_IDLE;
          end else begin
            step_nxt  = step_r + 7'd1;
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (put_en) begin
      case (pos_r[1:0])
        2'd0:    cur_word_nxt = {put_val, cur_word_r[23:0]};
        2'd1:    cur_word_nxt = {cur_word_r[31:24], put_val, cur_word_r[15:0]};
        2'd2:    cur_word_nxt = {cur_word_r[31:16], put_val, cur_word_r[7:0]};
        default: cur_word_nxt = {cur_word_r[31:8], put_val};
      endcase
      pos_nxt = pos_r + 6'd1;
      if (pos_r == 6'd63) begin
        step_nxt  = 7'd0;
        ret_nxt   = after_st;
        state_nxt = ST_LOAD;
      end else begin
        state_nxt = after_st;
      end
    end
  end

  assign buf_we    = put_en && (pos_r[1:0] == 2'd3);
  assign buf_waddr = pos_r[5:2];

  always_ff @(posedge clk) begin
    if (buf_re) begin
      buf_rd_r <= buf_mem[buf_raddr];
    end
    if (buf_we) begin
      buf_mem[buf_waddr] <= cur_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      step_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      len_cnt_r   <= '0;
      last_r      <= 1'b0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      step_r      <= step_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      len_cnt_r   <= len_cnt_nxt;
      last_r      <= last_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_sr_r  <= byte_sr_nxt;
    cur_word_r <= cur_word_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_done_r <= out_done_nxt;
    for (int i = 0; i < 8; i++) begin
      work_r[i] <= work_nxt[i];
    end
    for (int i = 0; i < 16; i++) begin
      sched_r[i] <= sched_nxt[i];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_digest_done = out_done_r;

  `SHM_ASSERT(a_load_block_aligned, (state_r == ST_LOAD) |-> (pos_r == 6'd0), "compression started off a block boundary")
  `SHM_ASSERT(a_len_in_tail, (state_r == ST_PAD_LEN) |-> (pos_r[5:3] == 3'b111), "length bytes outside the block tail")
  `SHM_ASSERT_NEXT(a_len_fills_block, (state_r == ST_PAD_LEN) && (len_cnt_r == 3'd7), state_r == ST_LOAD, "last length byte did not close the block")
  `SHM_ASSERT(a_digest_aligned, ((state_r == ST_OUT_RD) || (state_r == ST_OUT_WR)) |-> (pos_r == 6'd0), "digest read with a partial block pending")
  `SHM_ASSERT(a_idle_no_bytes, (!in_stall) |-> (cnt_r == 3'd0), "word accepted while bytes of the previous one remain")

endmodule
